/* rtl/core/md5_byte_stream_hasher_defines.svh */
// Assertion macros for the MD5 byte-stream hasher.
`ifndef MD5_BYTE_STREAM_HASHER_DEFINES_SVH
`define MD5_BYTE_STREAM_HASHER_DEFINES_SVH

// Consequent must hold in the same cycle.
`define MD5BSH_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("md5bsh assertion failed");

// Consequent must hold in the next cycle.
`define MD5BSH_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("md5bsh assertion failed");

`endif

/* rtl/core/md5bsh_pkg.sv */
package md5bsh_pkg;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } res_t;

  localparam logic [31:0] MD5_IV [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] MD5_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] MD5_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

endpackage

/* rtl/core/md5bsh_front.sv */
module md5bsh_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             kind,
  input  logic [7:0]       data_byte,
  output logic             full,
  output logic             cmd_valid,
  output md5bsh_pkg::cmd_t cmd,
  input  logic             cmd_pop
);
  import md5bsh_pkg::*;

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] count;
  logic               do_push;
  logic               do_pop;
  cmd_t               in_cmd;

  assign full      = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;
  assign cmd       = mem[rd_ptr];

  always_comb begin
    in_cmd.is_end = (kind == KIND_END);
    in_cmd.data   = data_byte;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/md5bsh_back.sv */
module md5bsh_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  md5bsh_pkg::cmd_t cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output md5bsh_pkg::res_t res
);
  import md5bsh_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_LEN   = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_FOLD  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_PAD  = 2'd1;
  localparam logic [1:0] RET_EMIT = 2'd2;

  logic [2:0]  state;
  logic [1:0]  ret;
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [60:0] total;
  logic [5:0]  round;
  logic [1:0]  emit_idx;
  logic [31:0] a, b, c, d;

  logic [1:0]  grp;
  logic [3:0]  r4;
  logic [3:0]  g;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot64;
  logic [31:0] new_b;

  assign cmd_pop  = (state == S_IDLE) && cmd_valid;
  assign res_push = (state == S_EMIT) && !res_full;

  always_comb begin
    res.word  = chain[emit_idx];
    res.index = emit_idx;
    res.last  = (emit_idx == 2'd3);
  end

  always_comb begin
    grp = round[5:4];
    r4  = round[3:0];
    unique case (grp)
      2'd0: begin
        f = d ^ (b & (c ^ d));
        g = r4;
      end
      2'd1: begin
        f = c ^ (d & (b ^ c));
        g = r4 * 4'd5 + 4'd1;
      end
      2'd2: begin
        f = b ^ c ^ d;
        g = r4 * 4'd3 + 4'd5;
      end
      default: begin
        f = c ^ (b | ~d);
        g = r4 * 4'd7;
      end
    endcase
    sum   = a + f + MD5_K[round] + blk[g];
    rot64 = {sum, sum} << MD5_S[{grp, round[1:0]}];
    new_b = b + rot64[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= RET_IDLE;
      fill     <= '0;
      total    <= '0;
      round    <= '0;
      emit_idx <= '0;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= MD5_IV[i];
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.is_end) begin
              state <= S_PAD80;
            end else begin
              blk[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= cmd.data;
              fill  <= fill + 1'b1;
              total <= total + 1'b1;
              if (fill == 6'd63) begin
                a     <= chain[0];
                b     <= chain[1];
                c     <= chain[2];
                d     <= chain[3];
                round <= '0;
                ret   <= RET_IDLE;
                state <= S_ROUND;
              end
            end
          end
        end
        S_PAD80, S_PADZ: begin
          if (state == S_PADZ && fill == 6'd56) begin
            state <= S_LEN;
          end else begin
            blk[fill[5:2]][{fill[1:0], 3'b000} +: 8] <=
              (state == S_PAD80) ? PAD_MARK : 8'h00;
            fill <= fill + 1'b1;
            if (fill == 6'd63) begin
              a     <= chain[0];
              b     <= chain[1];
              c     <= chain[2];
              d     <= chain[3];
              round <= '0;
              ret   <= RET_PAD;
              state <= S_ROUND;
            end else begin
              state <= S_PADZ;
            end
          end
        end
        S_LEN: begin
          blk[14] <= {total[28:0], 3'b000};
          blk[15] <= total[60:29];
          a       <= chain[0];
          b       <= chain[1];
          c       <= chain[2];
          d       <= chain[3];
          round   <= '0;
          ret     <= RET_EMIT;
          state   <= S_ROUND;
        end
        S_ROUND: begin
          a     <= d;
          b     <= new_b;
          c     <= b;
          d     <= c;
          round <= round + 1'b1;
          if (round == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          unique case (ret)
            RET_PAD:  state <= S_PADZ;
            RET_EMIT: state <= S_EMIT;
            default:  state <= S_IDLE;
          endcase
        end
        S_EMIT: begin
          if (!res_full) begin
            emit_idx <= emit_idx + 1'b1;
            if (emit_idx == 2'd3) begin
              for (int i = 0; i < 4; i++) begin
                chain[i] <= MD5_IV[i];
              end
              fill  <= '0;
              total <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/md5bsh_outq.sv */
module md5bsh_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  input  md5bsh_pkg::res_t res,
  output logic             res_full,
  input  logic             pop,
  output logic             empty,
  output md5bsh_pkg::res_t head
);
  import md5bsh_pkg::*;

  res_t               mem [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wr_ptr;
  logic [RESQ_AW-1:0] rd_ptr;
  logic [RESQ_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign res_full = (count == RESQ_CW'(RESQ_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == RESQ_AW'(RESQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/md5_byte_stream_hasher.sv */
// Data beat: the back end stores the byte; every 64th byte also starts a compression
// (64 rounds at one round per cycle, then the chaining add), during which no byte is taken.
// End beat: padding, the length words, one or two compressions,
// then 4 result beats, one per cycle while the result queue has room.
// Reset (rst, synchronous, active high) empties both queues, loads the MD5 initial
// values and zeroes byte position and length; block words are not cleared.
module md5_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);
  import md5bsh_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;
  logic res_full;
  logic res_push;
  res_t res;
  res_t head;

  md5bsh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .kind      (kind),
    .data_byte (data_byte),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  md5bsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  md5bsh_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign digest_word = head.word;
  assign word_index  = head.index;
  assign last_word   = head.last;

endmodule

/* rtl/core/md5bsh_checker.sv */
`include "md5_byte_stream_hasher_defines.svh"

module md5bsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] digest_word,
  input logic [1:0]  word_index,
  input logic        last_word
);

  `MD5BSH_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, empty && !full)
  `MD5BSH_ASSERT_NOW(a_last_idx, clk, rst, !empty, last_word == (word_index == 2'd3))
  `MD5BSH_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(digest_word) && $stable(word_index))
  `MD5BSH_ASSERT_NEXT(a_idx_step, clk, rst, !empty && pop && !last_word && !$past(rst), empty || word_index == $past(word_index) + 2'd1)

endmodule

bind md5_byte_stream_hasher md5bsh_checker u_md5bsh_checker (.*);
